### src/tgarle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Shared types and constants of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned PixelWidth    = 32;
  localparam int unsigned RunWidth      = 8;
  localparam int unsigned DimWidth      = 16;
  localparam int unsigned CountWidth    = 32;
  localparam int unsigned BppWidth      = 3;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] REG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_IMAGE_WIDTH     = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_IMAGE_HEIGHT    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [BppWidth-1:0] BPP_RESET    = 3'd4;
  localparam logic [DimWidth-1:0] WIDTH_RESET  = 16'd1;
  localparam logic [DimWidth-1:0] HEIGHT_RESET = 16'd1;

  // Packet header fields.
  localparam logic [ByteWidth-1:0] RUN_FLAG   = 8'h80;
  localparam logic [ByteWidth-1:0] COUNT_MASK = 8'h7F;

  typedef struct packed {
    logic [PixelWidth-1:0] pixel_value;
    logic [RunWidth-1:0]   run_length;
    logic                  end_of_image;
    logic                  overrun;
  } result_t;

endpackage

### src/tgarle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE decoder channels
// Valid/ready channels for the byte stream and the decoded pixel results.
// ----------------------------------------------------------------------------
interface tgarle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tgarle_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  run_length;
  logic        end_of_image;
  logic        overrun;

  modport source (output valid, output pixel_value, output run_length,
                  output end_of_image, output overrun, input ready);
  modport sink (input valid, input pixel_value, input run_length,
                input end_of_image, input overrun, output ready);
endinterface

### src/tgarle_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE packet parser
// Holds the packet parse state and forms one pixel result per completed pixel.
// ----------------------------------------------------------------------------
module tgarle_parser (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic [tgarle_pkg::ByteWidth-1:0]      data_byte,
  input  logic                                  bpp_is_3,
  input  logic [tgarle_pkg::CountWidth-1:0]     total,
  output logic                                  res_push,
  output tgarle_pkg::result_t                   res
);

  typedef enum logic {
    PH_HEADER,
    PH_COLOR
  } phase_t;

  phase_t                                  phase;
  logic                                    is_run;
  logic [tgarle_pkg::RunWidth-1:0]         left;
  logic [1:0]                              idx;
  logic [tgarle_pkg::PixelWidth-1:0]       gather;
  logic [tgarle_pkg::CountWidth-1:0]       emitted;

  logic [tgarle_pkg::PixelWidth-1:0]       gather_next;
  logic                                    last_byte;
  logic [tgarle_pkg::RunWidth-1:0]         run_n;
  logic [tgarle_pkg::CountWidth-1:0]       remaining;
  logic [tgarle_pkg::CountWidth-1:0]       run_n_wide;
  logic [tgarle_pkg::RunWidth-1:0]         n_final;
  logic                                    eoi;
  logic [tgarle_pkg::RunWidth-1:0]         left_after;

  always_comb begin
    gather_next = gather | ({24'b0, data_byte} << {idx, 3'b000});
    last_byte   = bpp_is_3 ? (idx >= 2'd2) : (idx == 2'd3);
    run_n       = is_run ? left : 8'd1;
    if (run_n == 8'd0) begin
      run_n = 8'd1;
    end
    remaining   = (emitted < total) ? (total - emitted) : 32'd1;
    run_n_wide  = {24'b0, run_n};
    // A clamped run is shorter than the run itself, so it fits in eight bits.
    n_final     = (run_n_wide > remaining) ? remaining[7:0] : run_n;
    eoi         = (run_n_wide >= remaining);
    left_after  = (left > n_final) ? (left - n_final) : 8'd0;

    res_push         = accept && (phase == PH_COLOR) && last_byte;
    res.pixel_value  = gather_next;
    res.run_length   = n_final;
    res.end_of_image = eoi;
    res.overrun      = eoi && (left_after != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEADER;
      is_run  <= 1'b0;
      left    <= '0;
      idx     <= '0;
      gather  <= '0;
      emitted <= '0;
    end else if (accept) begin
      if (phase == PH_HEADER) begin
        is_run <= (data_byte & tgarle_pkg::RUN_FLAG) != 8'd0;
        left   <= (data_byte & tgarle_pkg::COUNT_MASK) + 8'd1;
        idx    <= '0;
        gather <= '0;
        phase  <= PH_COLOR;
      end else if (!last_byte) begin
        gather <= gather_next;
        idx    <= idx + 2'd1;
      end else begin
        gather <= '0;
        idx    <= '0;
        if (eoi) begin
          emitted <= '0;
          left    <= '0;
          phase   <= PH_HEADER;
        end else begin
          emitted <= emitted + run_n_wide;
          left    <= left_after;
          phase   <= (left_after == 8'd0) ? PH_HEADER : PH_COLOR;
        end
      end
    end
  end

  a_overrun_ends_image : assert property (@(posedge clk) disable iff (rst)
    (res_push && res.overrun) |-> res.end_of_image)
    else $error("overrun flagged on a result that does not end the image");

  a_run_nonzero : assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res.run_length != 8'd0))
    else $error("pixel result with zero run length");

  a_eoi_restarts : assert property (@(posedge clk) disable iff (rst)
    (res_push && res.end_of_image) |=> ((emitted == '0) && (phase == PH_HEADER)))
    else $error("pixel count or parse phase not restarted after image end");

endmodule

### src/tgarle_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE result buffer
// Two-entry output register with skid entry for the pixel result channel.
// ----------------------------------------------------------------------------
module tgarle_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tgarle_pkg::result_t push_data,
  output logic                can_take,
  output logic                head_valid,
  input  logic                head_ready,
  output tgarle_pkg::result_t head
);

  tgarle_pkg::result_t tail;
  logic                tail_valid;
  logic                pop;

  assign pop      = head_valid && head_ready;
  assign can_take = !tail_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (tail_valid) begin
          head       <= tail;
          tail_valid <= 1'b0;
        end else if (push) begin
          head <= push_data;
        end else begin
          head_valid <= 1'b0;
        end
      end else if (push) begin
        if (!head_valid) begin
          head       <= push_data;
          head_valid <= 1'b1;
        end else begin
          tail       <= push_data;
          tail_valid <= 1'b1;
        end
      end
    end
  end

  a_no_push_when_full : assert property (@(posedge clk) disable iff (rst)
    push |-> !tail_valid)
    else $error("result pushed into a full buffer");

  a_tail_needs_head : assert property (@(posedge clk) disable iff (rst)
    tail_valid |-> head_valid)
    else $error("skid entry held without a head entry");

endmodule

### src/tga_rle_pixel_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes the run-length packet stream of a true-colour TGA image into pixels.
// ----------------------------------------------------------------------------
// The block takes the RLE payload one byte per transfer on byte_in. Header
// bytes and all colour bytes but the last of a pixel give no result; the
// last colour byte of a pixel gives one transfer on result_out carrying the
// packed colour, its run length, and the end-of-image and overrun flags.
// A run packet gives one result for the whole run; a raw packet gives one
// result of run length one per literal pixel.
//
// A result is registered in the result buffer before it is presented on
// result_out. Throughput: one byte per cycle while byte_in.ready is high,
// set by the combinational parse logic between parse state and result buffer.
//
// The result side has a two-entry buffer (output register plus skid entry),
// so a byte can still be taken while one finished result waits. When the
// receiver stalls and both entries are full, byte_in.ready falls until the
// receiver takes a result; nothing is lost or reordered.
//
// Synchronous reset returns the configuration to 4 bytes per pixel and a 1x1
// image, clears the parse state and pixel count, and empties the buffer.
// The pixel total width*height is registered, so byte_in.ready is held low
// in the cycle after a configuration write while the total catches up.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  tgarle_byte_if.sink                            byte_in,
  tgarle_result_if.source                        result_out,
  input  logic                                   cfg_write_en,
  input  logic [tgarle_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [tgarle_pkg::CfgDataWidth-1:0]    cfg_data
);

  // Configuration registers.
  logic [tgarle_pkg::BppWidth-1:0]   bytes_per_pixel;
  logic [tgarle_pkg::DimWidth-1:0]   image_width;
  logic [tgarle_pkg::DimWidth-1:0]   image_height;

  // Registered pixel total; a zero dimension counts as one.
  logic [tgarle_pkg::CountWidth-1:0] total;
  logic [tgarle_pkg::DimWidth-1:0]   width_eff;
  logic [tgarle_pkg::DimWidth-1:0]   height_eff;
  // High in the cycle after a configuration write, while the total is stale.
  logic                              cfg_settle;

  logic                              accept;
  logic                              res_push;
  tgarle_pkg::result_t               res;
  logic                              can_take;
  tgarle_pkg::result_t               head;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= tgarle_pkg::BPP_RESET;
      image_width     <= tgarle_pkg::WIDTH_RESET;
      image_height    <= tgarle_pkg::HEIGHT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        tgarle_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        tgarle_pkg::REG_IMAGE_WIDTH:     image_width     <= cfg_data;
        tgarle_pkg::REG_IMAGE_HEIGHT:    image_height    <= cfg_data;
        default: begin
          // Writes to unused indexes are ignored.
        end
      endcase
    end
  end

  assign width_eff  = (image_width == '0) ? 16'd1 : image_width;
  assign height_eff = (image_height == '0) ? 16'd1 : image_height;

  // A 16 by 16 product fits the 32-bit pixel count exactly.
  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= 32'd1;
      cfg_settle <= 1'b0;
    end else begin
      total      <= {16'b0, width_eff} * {16'b0, height_eff};
      cfg_settle <= cfg_write_en;
    end
  end

  assign byte_in.ready = can_take && !cfg_settle;
  assign accept        = byte_in.valid && byte_in.ready;

  tgarle_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (byte_in.data_byte),
    .bpp_is_3  (bytes_per_pixel == 3'd3),
    .total     (total),
    .res_push  (res_push),
    .res       (res)
  );

  tgarle_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_push),
    .push_data  (res),
    .can_take   (can_take),
    .head_valid (result_out.valid),
    .head_ready (result_out.ready),
    .head       (head)
  );

  assign result_out.pixel_value  = head.pixel_value;
  assign result_out.run_length   = head.run_length;
  assign result_out.end_of_image = head.end_of_image;
  assign result_out.overrun      = head.overrun;

endmodule
